### design/lrce_pkg.sv
// Package for the LZW RGB channel encoder: sizes, command and status structs.
// Used by every module of the block; depends on nothing.
package lrce_pkg;

   localparam int DICT_SIZE = 4096;
   localparam int CODE_W = $clog2(DICT_SIZE);
   localparam int NEXT_W = CODE_W + 1;
   localparam int LIMIT_W = 13;
   localparam int CMP_W = (NEXT_W > LIMIT_W) ? NEXT_W : LIMIT_W;
   localparam int OUT_CODE_W = 12;
   localparam int BYTE_W = 8;
   localparam int KEY_W = OUT_CODE_W + BYTE_W;
   localparam int CH_W = 2;
   localparam int MEM_DEPTH = 4 * DICT_SIZE;
   localparam int ADDR_W = CH_W + CODE_W;
   localparam logic [NEXT_W-1:0] FIRST_FREE = NEXT_W'(256);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
   localparam logic [CH_W-1:0] CH_RED = 2'd0;
   localparam logic [CH_W-1:0] CH_BLUE = 2'd2;
   localparam logic [0:0] REG_DICT_LIMIT = 1'b0;

   typedef struct packed {
      logic load;
      logic set_first;
      logic scan_start;
      logic scan_inc;
      logic rd_en;
      logic take_hit;
      logic emit;
      logic emit_flush;
      logic ch_inc;
      logic ch_zero;
      logic clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic pv;
      logic top_empty;
      logic scan_last;
      logic hit;
      logic ch_last;
      logic eoi;
      logic can_emit;
      logic pend_v;
   } sts_type;

endpackage

### design/lrce_ctrl.sv
// Controller state machine of the LZW RGB channel encoder.
// Depends on lrce_pkg; drives the datapath lrce_dp through command structs.
module lrce_ctrl import lrce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHAN = 3'd1;
   localparam logic [2:0] S_RD = 3'd2;
   localparam logic [2:0] S_CMP = 3'd3;
   localparam logic [2:0] S_MISS = 3'd4;
   localparam logic [2:0] S_NEXT = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;
   localparam logic [2:0] S_FIN = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.ch_zero = 1'b1;
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            if (!sts.pv) begin
               cmd.set_first = 1'b1;
               state_in = S_NEXT;
            end else if (sts.top_empty) begin
               state_in = S_MISS;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in = S_NEXT;
            end else if (sts.scan_last) begin
               state_in = S_MISS;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in = S_RD;
            end
         end
         S_MISS: begin
            if (sts.can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!sts.ch_last) begin
               cmd.ch_inc = 1'b1;
               state_in = S_CHAN;
            end else if (sts.eoi) begin
               cmd.ch_zero = 1'b1;
               state_in = S_FLUSH;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FLUSH: begin
            if (sts.can_emit) begin
               cmd.emit = 1'b1;
               cmd.emit_flush = 1'b1;
               if (sts.ch_last) begin
                  state_in = S_FIN;
               end else begin
                  cmd.ch_inc = 1'b1;
               end
            end
         end
         S_FIN: begin
            if (!sts.pend_v) begin
               if (sts.eoi) begin
                  cmd.clear = 1'b1;
               end
               state_in = S_IDLE;
            end else if (sts.can_emit) begin
               cmd.finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/lrce_dp.sv
// Datapath of the LZW RGB channel encoder: dictionary memory, channel state,
// configuration register and result registers. Depends on lrce_pkg.
module lrce_dp import lrce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [BYTE_W-1:0]     req_red,
   input  logic [BYTE_W-1:0]     req_green,
   input  logic [BYTE_W-1:0]     req_blue,
   input  logic                  req_end_of_image,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [OUT_CODE_W-1:0] rsp_code,
   output logic                  rsp_flush_code,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [0:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [KEY_W-1:0]      mem [MEM_DEPTH];
   logic [KEY_W-1:0]      rdata_ff;
   logic [BYTE_W-1:0]     pix_ff [3];
   logic                  eoi_ff;
   logic [CH_W-1:0]       ch_ff;
   logic [CODE_W-1:0]     scan_ff;
   logic [NEXT_W-1:0]     next_ff [3];
   logic [CODE_W-1:0]     prefix_ff [3];
   logic [2:0]            pv_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  pend_v_ff;
   logic [CH_W-1:0]       pend_ch_ff;
   logic [OUT_CODE_W-1:0] pend_code_ff;
   logic                  pend_fl_ff;
   logic                  out_v_ff;
   logic                  out_v_in;
   logic [CH_W-1:0]       out_ch_ff;
   logic [OUT_CODE_W-1:0] out_code_ff;
   logic                  out_fl_ff;
   logic                  out_last_ff;
   logic [BYTE_W-1:0]     cur_byte;
   logic [KEY_W-1:0]      cur_key;
   logic [CMP_W-1:0]      limit_eff;
   logic                  room;
   logic                  out_load;
   logic                  out_last_load;
   logic                  mem_we;
   logic [ADDR_W-1:0]     wr_addr;

   assign pready = 1'b1;
   assign prdata = {{(32 - LIMIT_W){1'b0}}, limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (psel && penable && pwrite && (paddr == REG_DICT_LIMIT)) begin
         limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   assign cur_byte = pix_ff[ch_ff];
   assign cur_key = {OUT_CODE_W'(prefix_ff[ch_ff]), cur_byte};
   assign limit_eff = (CMP_W'(limit_ff) > CMP_W'(DICT_SIZE)) ? CMP_W'(DICT_SIZE)
                                                             : CMP_W'(limit_ff);
   assign room = CMP_W'(next_ff[ch_ff]) < limit_eff;
   assign mem_we = cmd.emit && !cmd.emit_flush && room;
   assign wr_addr = {ch_ff, next_ff[ch_ff][CODE_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cur_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[{ch_ff, scan_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff[0] <= req_red;
         pix_ff[1] <= req_green;
         pix_ff[2] <= req_blue;
         eoi_ff <= req_end_of_image;
      end
      if (cmd.ch_zero) begin
         ch_ff <= CH_RED;
      end else if (cmd.ch_inc) begin
         ch_ff <= ch_ff + 1'b1;
      end
      if (cmd.scan_start) begin
         scan_ff <= FIRST_FREE[CODE_W-1:0];
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < 3; i++) begin
            next_ff[i] <= FIRST_FREE;
            prefix_ff[i] <= '0;
         end
         pv_ff <= '0;
      end else begin
         if (cmd.set_first) begin
            prefix_ff[ch_ff] <= CODE_W'(cur_byte);
            pv_ff[ch_ff] <= 1'b1;
         end
         if (cmd.take_hit) begin
            prefix_ff[ch_ff] <= scan_ff;
         end
         if (cmd.emit && !cmd.emit_flush) begin
            prefix_ff[ch_ff] <= CODE_W'(cur_byte);
            if (room) begin
               next_ff[ch_ff] <= next_ff[ch_ff] + 1'b1;
            end
         end
      end
   end

   assign out_load = (cmd.emit && pend_v_ff) || cmd.finish;
   assign out_last_load = cmd.finish;
   assign out_v_in = out_load || (out_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         if (cmd.emit) begin
            pend_v_ff <= 1'b1;
         end else if (cmd.finish) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_ch_ff <= ch_ff;
         pend_code_ff <= OUT_CODE_W'(prefix_ff[ch_ff]);
         pend_fl_ff <= cmd.emit_flush;
      end
      if (out_load) begin
         out_ch_ff <= pend_ch_ff;
         out_code_ff <= pend_code_ff;
         out_fl_ff <= pend_fl_ff;
         out_last_ff <= out_last_load;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_channel = out_ch_ff;
   assign rsp_code = out_code_ff;
   assign rsp_flush_code = out_fl_ff;
   assign rsp_last = out_last_ff;

   assign sts.pv = pv_ff[ch_ff];
   assign sts.top_empty = (next_ff[ch_ff] == FIRST_FREE);
   assign sts.scan_last = ({1'b0, scan_ff} + 1'b1) == next_ff[ch_ff];
   assign sts.hit = (rdata_ff == cur_key);
   assign sts.ch_last = (ch_ff == CH_BLUE);
   assign sts.eoi = eoi_ff;
   assign sts.can_emit = !pend_v_ff || !out_v_ff;
   assign sts.pend_v = pend_v_ff;

endmodule

### design/lzw_rgb_channel_encoder_core.sv
// Top level of the LZW RGB channel encoder.
// Depends on lrce_pkg and instantiates lrce_ctrl and lrce_dp.
//
// Pixels arrive on the req_ channel (red, green, blue, end_of_image); LZW codes
// leave on the rsp_ channel, each tagged with its colour channel, a flush flag
// for the end-of-image prefix flush, and last on the final code of a pixel.
// A pixel may cause no code at all.
// Each colour channel keeps its own dictionary in a block memory. A byte is
// matched by scanning that channel's entries from code 256 upward, one entry
// at a time over the single memory read port: each entry is read in S_RD and
// compared in S_CMP. One pixel is processed at a time. The final code of a
// pixel is presented in the cycle before req_ready rises again.
// The dict_limit register sits at address 0 of the APB port; write it only
// while the block is idle.
// Reset clears the controller, the prefixes and the dictionary fill counts and
// sets dict_limit to 4096; the dictionary memory itself is not cleared. After
// an end-of-image pixel every channel returns to that same empty state.
// A stalled receiver holds the current code on the output register; one more
// code waits in a holding register, and then the block pauses until a transfer
// on the result channel frees a slot.
module lzw_rgb_channel_encoder_core import lrce_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_red,
   input  logic [BYTE_W-1:0]     req_green,
   input  logic [BYTE_W-1:0]     req_blue,
   input  logic                  req_end_of_image,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [OUT_CODE_W-1:0] rsp_code,
   output logic                  rsp_flush_code,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [0:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cmd_type cmd;
   sts_type sts;

   lrce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrce_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_end_of_image (req_end_of_image),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_code         (rsp_code),
      .rsp_flush_code   (rsp_flush_code),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

endmodule
